[hw/rtl/sensor_frame_crc_convert_assert.svh]
// Assertion macros used by the top-level RTL file to check its own logic.
`ifndef SENSOR_FRAME_CRC_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CONVERT_ASSERT_SVH

`ifndef SYNTH
`define SFCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sensor_frame_crc_convert: implication check failed");
`define SFCC_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("sensor_frame_crc_convert: forbidden condition seen");
`else
`define SFCC_ASSERT_IMP(lbl, ante, cons)
`define SFCC_ASSERT_NEVER(lbl, expr)
`endif

`endif

[hw/rtl/sfcc_pkg.sv]
`default_nettype none

package sfcc_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = QAW + 1;

  localparam logic [7:0]  CRC_POLY  = 8'h31;
  localparam logic [7:0]  CRC_INIT  = 8'hFF;
  localparam logic [7:0]  BYTE_ONES = 8'hFF;

  localparam logic [30:0] T_SPAN    = 31'd17500;
  localparam logic [30:0] H_SPAN    = 31'd12500;
  localparam logic [14:0] T_OFFSET  = 15'd4500;
  localparam logic [13:0] H_OFFSET  = 14'd600;
  localparam logic [13:0] H_MAX     = 14'd10000;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_ALL_ONES = 2'd1,
    ST_TEMP_CRC = 2'd2,
    ST_HUM_CRC  = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    POS_T_HI  = 6'b000001,
    POS_T_LO  = 6'b000010,
    POS_T_CRC = 6'b000100,
    POS_H_HI  = 6'b001000,
    POS_H_LO  = 6'b010000,
    POS_H_CRC = 6'b100000
  } pos_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } frame_t;

  typedef struct packed {
    status_t            status;
    logic signed [14:0] temp_centi;
    logic [13:0]        hum_centi;
    logic [15:0]        raw_t;
    logic [15:0]        raw_h;
  } result_t;

  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Floor division by 65535: the shifted estimate is at most one low, so one
  // remainder check corrects it.
  function automatic logic [14:0] div_65535(input logic [30:0] x);
    logic [31:0] s;
    logic [15:0] q;
    logic [31:0] r;
    s = {1'b0, x} + {17'd0, x[30:16]};
    q = s[31:16];
    r = {1'b0, x} - {q, 16'd0} + {16'd0, q};
    if (r >= 32'd65535) begin
      q = q + 16'd1;
    end
    return q[14:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/sfcc_front.sv]
`default_nettype none

module sfcc_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            frame_start,
  output sfcc_pkg::frame_t     push_data,
  output logic                 push
);

  sfcc_pkg::pos_t pos_r, pos_nxt, pos_c;
  logic [7:0]     crc_r, crc_nxt, crc_c, crc_fed;
  logic           ones_r, ones_nxt, ones_c;
  logic           tbad_r, tbad_nxt, tbad_c;
  logic [15:0]    tword_r, tword_nxt;
  logic [7:0]     hhi_r, hhi_nxt;
  logic [7:0]     hlo_r, hlo_nxt;
  logic           restart;
  logic           hit;

  always_comb begin
    restart = frame_start || !(pos_r inside {sfcc_pkg::POS_T_HI, sfcc_pkg::POS_T_LO,
                                             sfcc_pkg::POS_T_CRC, sfcc_pkg::POS_H_HI,
                                             sfcc_pkg::POS_H_LO, sfcc_pkg::POS_H_CRC});
    pos_c   = restart ? sfcc_pkg::POS_T_HI : pos_r;
    crc_c   = restart ? sfcc_pkg::CRC_INIT : crc_r;
    tbad_c  = restart ? 1'b0 : tbad_r;
    ones_c  = (restart || ones_r) && (rx_byte == sfcc_pkg::BYTE_ONES);
    crc_fed = sfcc_pkg::crc8_feed(crc_c, rx_byte);
    hit     = 1'b0;

    pos_nxt   = pos_c;
    crc_nxt   = crc_fed;
    ones_nxt  = ones_c;
    tbad_nxt  = tbad_c;
    tword_nxt = tword_r;
    hhi_nxt   = hhi_r;
    hlo_nxt   = hlo_r;

    unique case (pos_c)
      sfcc_pkg::POS_T_HI: begin
        tword_nxt = {rx_byte, 8'd0};
        pos_nxt   = sfcc_pkg::POS_T_LO;
      end
      sfcc_pkg::POS_T_LO: begin
        tword_nxt = {tword_r[15:8], rx_byte};
        pos_nxt   = sfcc_pkg::POS_T_CRC;
      end
      sfcc_pkg::POS_T_CRC: begin
        tbad_nxt = (crc_c != rx_byte);
        crc_nxt  = sfcc_pkg::CRC_INIT;
        pos_nxt  = sfcc_pkg::POS_H_HI;
      end
      sfcc_pkg::POS_H_HI: begin
        hhi_nxt = rx_byte;
        pos_nxt = sfcc_pkg::POS_H_LO;
      end
      sfcc_pkg::POS_H_LO: begin
        hlo_nxt = rx_byte;
        pos_nxt = sfcc_pkg::POS_H_CRC;
      end
      sfcc_pkg::POS_H_CRC: begin
        hit      = 1'b1;
        pos_nxt  = sfcc_pkg::POS_T_HI;
        crc_nxt  = sfcc_pkg::CRC_INIT;
        tbad_nxt = 1'b0;
        ones_nxt = 1'b1;
      end
      default: begin
        pos_nxt = sfcc_pkg::POS_T_HI;
      end
    endcase

    if (ones_c) begin
      push_data.status = sfcc_pkg::ST_ALL_ONES;
    end else if (tbad_c) begin
      push_data.status = sfcc_pkg::ST_TEMP_CRC;
    end else if (crc_c != rx_byte) begin
      push_data.status = sfcc_pkg::ST_HUM_CRC;
    end else begin
      push_data.status = sfcc_pkg::ST_GOOD;
    end
    push_data.raw_t = tword_r;
    push_data.raw_h = {hhi_r, hlo_r};
    push            = accept && hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= sfcc_pkg::POS_T_HI;
      crc_r  <= sfcc_pkg::CRC_INIT;
      ones_r <= 1'b1;
      tbad_r <= 1'b0;
    end else if (accept) begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      ones_r <= ones_nxt;
      tbad_r <= tbad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tword_r <= tword_nxt;
      hhi_r   <= hhi_nxt;
      hlo_r   <= hlo_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfcc_queue.sv]
`default_nettype none

module sfcc_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sfcc_pkg::frame_t push_data,
  input  wire logic             pop,
  output sfcc_pkg::frame_t      pop_data,
  output logic                  not_empty,
  output logic                  full
);

  sfcc_pkg::frame_t              mem_r [sfcc_pkg::QDEPTH];
  logic [sfcc_pkg::QAW-1:0]      wr_r, wr_nxt;
  logic [sfcc_pkg::QAW-1:0]      rd_r, rd_nxt;
  logic [sfcc_pkg::QCW-1:0]      cnt_r, cnt_nxt;

  always_comb begin
    full      = (cnt_r == sfcc_pkg::QCW'(sfcc_pkg::QDEPTH));
    not_empty = (cnt_r != '0);
    pop_data  = mem_r[rd_r];
    wr_nxt    = push ? wr_r + 1'b1 : wr_r;
    rd_nxt    = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt   = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sfcc_back.sv]
`default_nettype none

module sfcc_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire sfcc_pkg::frame_t q_data,
  output logic                  q_pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output sfcc_pkg::result_t     res_data
);

  logic               v1_r, v2_r, v3_r;
  logic               adv1, adv2, adv3;
  sfcc_pkg::frame_t   f1_r, f2_r;
  logic [30:0]        pt1_r, ph1_r;
  logic [14:0]        qt2_r, qh2_r;
  sfcc_pkg::result_t  res_r, res_nxt;
  logic [13:0]        hd;

  always_comb begin
    adv3  = !v3_r || res_ready;
    adv2  = !v2_r || adv3;
    adv1  = !v1_r || adv2;
    q_pop = q_valid && adv1;

    hd                 = qh2_r[13:0] - sfcc_pkg::H_OFFSET;
    res_nxt.status     = f2_r.status;
    res_nxt.raw_t      = f2_r.raw_t;
    res_nxt.raw_h      = f2_r.raw_h;
    res_nxt.temp_centi = '0;
    res_nxt.hum_centi  = '0;
    if (f2_r.status == sfcc_pkg::ST_GOOD) begin
      res_nxt.temp_centi = qt2_r - sfcc_pkg::T_OFFSET;
      if (qh2_r[13:0] < sfcc_pkg::H_OFFSET) begin
        res_nxt.hum_centi = '0;
      end else if (hd > sfcc_pkg::H_MAX) begin
        res_nxt.hum_centi = sfcc_pkg::H_MAX;
      end else begin
        res_nxt.hum_centi = hd;
      end
    end
    res_valid = v3_r;
    res_data  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= q_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      f1_r  <= q_data;
      pt1_r <= 31'(q_data.raw_t) * sfcc_pkg::T_SPAN;
      ph1_r <= 31'(q_data.raw_h) * sfcc_pkg::H_SPAN;
    end
    if (adv2) begin
      f2_r  <= f1_r;
      qt2_r <= sfcc_pkg::div_65535(pt1_r);
      qh2_r <= sfcc_pkg::div_65535(ph1_r);
    end
    if (adv3) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sensor_frame_crc_convert.sv]
// Channel  Direction  tdata                                  tuser
// in_      slave      [7:0] rx_byte                          [0] frame_start
// out_     master     [14:0] temperature_centi, [28:15]      [1:0] status
//                     humidity_centi, [44:29] raw_temperature,
//                     [60:45] raw_humidity, [63:61] zero
// One byte is taken in every cycle while the four-entry frame queue has room.
// After the sixth byte's beat a result passes through the queue, written at that beat,
// then through the multiply, divide-by-65535 and scaling stages, each registered.
// Reset (synchronous, active low) restarts the frame and empties the queue.
// A stalled output holds the back pipeline; the front runs on until the queue fills.
`default_nettype none

`include "sensor_frame_crc_convert_assert.svh"

module sensor_frame_crc_convert (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] frame_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // temperature_centi, humidity_centi, raw_t, raw_h
  output logic [1:0]       out_tuser   // [1:0] status
);

  sfcc_pkg::frame_t  push_data, pop_data;
  sfcc_pkg::result_t res;
  logic              push, pop, not_empty, full, accept;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;

  sfcc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .rx_byte     (in_tdata),
    .frame_start (in_tuser),
    .push_data   (push_data),
    .push        (push)
  );

  sfcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (not_empty),
    .full      (full)
  );

  sfcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (not_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (res)
  );

  assign out_tdata = {3'd0, res.raw_h, res.raw_t, res.hum_centi, res.temp_centi};
  assign out_tuser = res.status;

  `SFCC_ASSERT_IMP(a_err_zero, out_tvalid && (out_tuser != sfcc_pkg::ST_GOOD), out_tdata[28:0] == 29'd0)
  `SFCC_ASSERT_NEVER(a_hum_sat, out_tvalid && (out_tdata[28:15] > 14'd10000))
  `SFCC_ASSERT_IMP(a_temp_range, out_tvalid, $signed(out_tdata[14:0]) >= -15'sd4500)

endmodule

`default_nettype wire

[test/tb_top.sv]
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TARGET_BYTES = 1350;
  localparam int TAIL_BYTES   = 150;
  localparam int DRAIN_AT     = 700;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 120;
  localparam int SETTLE       = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  rx_beat_t pending_bytes[$];
  sfcc_pkg::result_t expected_readings[$];

  int bytes_sent = 0;
  int readings_seen = 0;
  int failures = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit draining = 1'b0;
  bit drain_done = 1'b0;
  bit hold_done = 1'b0;
  rx_beat_t beat_now;

  // Receiver's own view of the frame in progress.
  sfcc_pkg::pos_t frame_pos = sfcc_pkg::POS_T_HI;
  logic [7:0] frame_crc = sfcc_pkg::CRC_INIT;
  logic [15:0] temp_word = 16'h0000;
  logic [7:0] hum_hi = 8'h00;
  logic [7:0] hum_lo = 8'h00;
  logic       temp_bad = 1'b0;
  logic       all_ones = 1'b1;

  sensor_frame_crc_convert i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4ns clk = ~clk;

  function automatic logic [7:0] crc8_next(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ data[i];
      c = {c[6:0], 1'b0} ^ (fb ? sfcc_pkg::CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  task automatic restart_frame();
    frame_pos = sfcc_pkg::POS_T_HI;
    frame_crc = sfcc_pkg::CRC_INIT;
    temp_bad = 1'b0;
    all_ones = 1'b1;
  endtask

  task automatic decode_sensor_byte(input logic [7:0] b, input logic start);
    sfcc_pkg::result_t r;
    logic [31:0] scaled;
    logic [31:0] shifted;
    logic [15:0] raw_h;
    if (start) begin
      restart_frame();
    end
    if (b != sfcc_pkg::BYTE_ONES) begin
      all_ones = 1'b0;
    end
    case (frame_pos)
      sfcc_pkg::POS_T_HI: begin
        temp_word = {b, 8'h00};
        frame_crc = crc8_next(frame_crc, b);
        frame_pos = sfcc_pkg::POS_T_LO;
      end
      sfcc_pkg::POS_T_LO: begin
        temp_word[7:0] = b;
        frame_crc = crc8_next(frame_crc, b);
        frame_pos = sfcc_pkg::POS_T_CRC;
      end
      sfcc_pkg::POS_T_CRC: begin
        temp_bad = (frame_crc != b);
        frame_crc = sfcc_pkg::CRC_INIT;
        frame_pos = sfcc_pkg::POS_H_HI;
      end
      sfcc_pkg::POS_H_HI: begin
        hum_hi = b;
        frame_crc = crc8_next(frame_crc, b);
        frame_pos = sfcc_pkg::POS_H_LO;
      end
      sfcc_pkg::POS_H_LO: begin
        hum_lo = b;
        frame_crc = crc8_next(frame_crc, b);
        frame_pos = sfcc_pkg::POS_H_CRC;
      end
      default: begin
        raw_h = {hum_hi, hum_lo};
        r = '0;
        r.raw_t = temp_word;
        r.raw_h = raw_h;
        if (all_ones) begin
          r.status = sfcc_pkg::ST_ALL_ONES;
        end else if (temp_bad) begin
          r.status = sfcc_pkg::ST_TEMP_CRC;
        end else if (frame_crc != b) begin
          r.status = sfcc_pkg::ST_HUM_CRC;
        end else begin
          r.status = sfcc_pkg::ST_GOOD;
        end
        if (r.status == sfcc_pkg::ST_GOOD) begin
          scaled = (32'd17500 * {16'd0, temp_word}) / 32'd65535;
          shifted = scaled - 32'd4500;
          r.temp_centi = shifted[14:0];
          scaled = (32'd12500 * {16'd0, raw_h}) / 32'd65535;
          if (scaled < 32'd600) begin
            r.hum_centi = 14'd0;
          end else if (scaled - 32'd600 > 32'd10000) begin
            r.hum_centi = 14'd10000;
          end else begin
            shifted = scaled - 32'd600;
            r.hum_centi = shifted[13:0];
          end
        end
        expected_readings.push_back(r);
        restart_frame();
      end
    endcase
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic start);
    rx_beat_t x;
    x.data = b;
    x.start = start;
    pending_bytes.push_back(x);
  endtask

  task automatic queue_frame(input logic [15:0] t, input logic [15:0] h, input logic mark,
                             input bit bad_t, input bit bad_h);
    logic [7:0] ct;
    logic [7:0] ch;
    ct = crc8_next(crc8_next(sfcc_pkg::CRC_INIT, t[15:8]), t[7:0]);
    ch = crc8_next(crc8_next(sfcc_pkg::CRC_INIT, h[15:8]), h[7:0]);
    if (bad_t) begin
      ct = ct ^ 8'($urandom_range(1, 255));
    end
    if (bad_h) begin
      ch = ch ^ 8'($urandom_range(1, 255));
    end
    queue_byte(t[15:8], mark);
    queue_byte(t[7:0], 1'b0);
    queue_byte(ct, 1'b0);
    queue_byte(h[15:8], 1'b0);
    queue_byte(h[7:0], 1'b0);
    queue_byte(ch, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(3140, 3152));
      3: return 16'($urandom_range(55570, 55582));
      4: return 16'($urandom_range(16846, 16858));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic check_reading();
    sfcc_pkg::result_t want;
    if (expected_readings.size() == 0) begin
      $error("reading with none expected: tuser %0h, tdata %0h", out_tuser, out_tdata);
      failures++;
    end else begin
      want = expected_readings.pop_front();
      if (out_tuser !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_tuser);
        failures++;
      end
      if ($signed(out_tdata[14:0]) !== want.temp_centi) begin
        $error("temperature_centi: expected %0d, got %0d", want.temp_centi,
               $signed(out_tdata[14:0]));
        failures++;
      end
      if (out_tdata[28:15] !== want.hum_centi) begin
        $error("humidity_centi: expected %0d, got %0d", want.hum_centi, out_tdata[28:15]);
        failures++;
      end
      if (out_tdata[44:29] !== want.raw_t) begin
        $error("raw_temperature: expected %0h, got %0h", want.raw_t, out_tdata[44:29]);
        failures++;
      end
      if (out_tdata[60:45] !== want.raw_h) begin
        $error("raw_humidity: expected %0h, got %0h", want.raw_h, out_tdata[60:45]);
        failures++;
      end
      if (out_tdata[63:61] !== 3'b000) begin
        $error("tdata padding: expected 0, got %0h", out_tdata[63:61]);
        failures++;
      end
    end
    readings_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_sensor_byte(in_tdata, in_tuser);
        bytes_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (bytes_sent == DRAIN_AT && !drain_done) begin
          draining = 1'b1;
        end
        if (draining && expected_readings.size() == 0) begin
          draining = 1'b0;
          drain_done = 1'b1;
        end
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (draining || pending_bytes.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (pending_bytes.size() > TAIL_BYTES && (bytes_sent / 120) % 3 != 2 &&
                     $urandom_range(0, 7) == 0) begin
          send_gap = $urandom_range(0, 3);
          in_tvalid <= 1'b0;
        end else begin
          beat_now = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= beat_now.data;
          in_tuser <= beat_now.start;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        check_reading();
      end
      // One long hold-off, so that the frame queue fills and the input stalls.
      if (!hold_done && readings_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (pending_bytes.size() > TAIL_BYTES && (readings_seen / 20) % 3 != 1 &&
                   $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int     kind;
    int     cut;
    int     spot;
    bit     need_mark;
    logic   mark;
    need_mark = 1'b0;

    for (int i = 0; i < 6; i++) begin
      queue_byte(8'hFF, i == 0);
    end
    queue_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0);
    queue_byte(8'h5A, 1'b1);
    queue_frame(16'hFFFF, 16'h0000, 1'b1, 1'b1, 1'b0);
    queue_frame(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 1'b0,
                1'b0, 1'b1);

    while (pending_bytes.size() < TARGET_BYTES) begin
      kind = $urandom_range(0, 19);
      mark = need_mark ? 1'b1 : 1'($urandom_range(0, 1));
      need_mark = 1'b0;
      if (kind <= 9) begin
        queue_frame(pick_word(), pick_word(), mark, 1'b0, 1'b0);
      end else if (kind <= 12) begin
        queue_frame(pick_word(), pick_word(), mark, kind != 11, kind != 10);
      end else if (kind <= 14) begin
        spot = (kind == 14) ? $urandom_range(0, 5) : 6;
        for (int i = 0; i < 6; i++) begin
          queue_byte((i == spot) ? 8'($urandom_range(0, 254)) : 8'hFF, (i == 0) && mark);
        end
      end else if (kind <= 16) begin
        cut = $urandom_range(1, 5);
        for (int i = 0; i < cut; i++) begin
          queue_byte(8'($urandom_range(0, 255)), (i == 0) && mark);
        end
        queue_frame(pick_word(), pick_word(), 1'b1, 1'b0, 1'b0);
      end else begin
        cut = $urandom_range(1, 6);
        for (int i = 0; i < cut; i++) begin
          queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        need_mark = 1'b1;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin : finish_run
    wait (rst_n);
    while (pending_bytes.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (expected_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
    if (failures == 0 && expected_readings.size() == 0) begin
      $display("sensor_frame_crc_convert test passed");
    end else begin
      $display("sensor_frame_crc_convert test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("sensor_frame_crc_convert test failed");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+hw/rtl
hw/rtl/sfcc_pkg.sv
hw/rtl/sfcc_front.sv
hw/rtl/sfcc_queue.sv
hw/rtl/sfcc_back.sv
hw/rtl/sensor_frame_crc_convert.sv
test/tb_top.sv
